>>> design/art_pkg.sv
package art_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int PAGE_SHIFT  = 12;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_RESIZE = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_OVERLAP   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] lookup_address;
    logic [63:0] region_start;
    logic [63:0] region_end;
    logic [15:0] region_flags;
    logic [3:0]  region_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [3:0]  found_index;
    logic [63:0] found_start;
    logic [63:0] found_end;
    logic [15:0] found_flags;
    logic [4:0]  regions_in_use;
  } out_word_t;

  // one table entry as held in the ram
  typedef struct packed {
    logic [63:0] rstart;
    logic [63:0] rend;
    logic [15:0] rflags;
  } entry_t;

  // kind of result, also selects the table side effects
  typedef enum logic [3:0] {
    RK_NOT_FOUND,
    RK_HIT,
    RK_INVALID,
    RK_OVERLAP,
    RK_FULL,
    RK_BAD_INDEX,
    RK_RS_BAD,
    RK_RS_OK,
    RK_INS_OK,
    RK_RM_OK
  } res_kind_t;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_M1,
    RD_PTR_P1,
    RD_IDX
  } rd_sel_t;

  typedef enum logic [2:0] {
    P_HOLD,
    P_ZERO,
    P_INC,
    P_DEC,
    P_CNT,
    P_IDX,
    P_HIT
  } ptr_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_LK_CCHK,
    S_LK_CRES,
    S_LK_RD,
    S_LK_CHK,
    S_IN_RD,
    S_IN_CHK,
    S_IN_SH,
    S_IN_WR,
    S_RS_CHK,
    S_RM_CAP,
    S_RM_SH,
    S_RM_WR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic      capture;
    logic      rd_en;
    rd_sel_t   rd_sel;
    ptr_op_t   ptr_op;
    logic      prev_clr;
    logic      prev_ld;
    logic      pos_ld;
    logic      cap_ld;
    logic      wr_shift;
    logic      res_ld;
    res_kind_t res_kind;
    logic      out_ld;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic cache_ok;
    logic idx_bad;
    logic ins_bad;
    logic full;
    logic ptr_lt_cnt;
    logic ptr_gt_pos;
    logic ptr_p1_lt_cnt;
    logic contains;
    logic start_le_s;
    logic ovl_next;
    logic ovl_end;
    logic rs_bad;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/address_region_table_top.sv
// throughput: one word at a time; each table entry visited needs a registered ram read
//   and then a state that uses or moves the read data
// reset: rst_n synchronous active low clears the region count, the remembered hit,
//   the output valid and the controller; table contents are not cleared and are only read below the count
module address_region_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  art_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output art_pkg::out_word_t out_data
);
  import art_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  art_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  art_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/art_ram.sv
module art_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/art_datapath.sv
module art_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  art_pkg::dp_cmd_t  cmd,
  output art_pkg::dp_stat_t stat,
  input  art_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output art_pkg::out_word_t out_data
);
  import art_pkg::*;

  in_word_t          req_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic              hit_vld_r, hit_vld_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  pos_r;
  logic [63:0]       prev_end_r;
  logic              have_prev_r, have_prev_nxt;
  entry_t            cap_r;
  out_word_t         res_r, res_nxt;
  out_word_t         out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  entry_t            ram_q, wdata;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [CNT_W-1:0]  ptr_p1, ptr_m1, idx_ext;
  logic              prev_ovl;

  assign ptr_p1  = ptr_r + CNT_W'(1);
  assign ptr_m1  = ptr_r - CNT_W'(1);
  assign idx_ext = CNT_W'(req_r.region_index);

  // table storage
  art_ram #(.W($bits(entry_t)), .D(MAX_REGIONS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // read address
  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:    raddr = ptr_r[IDX_W-1:0];
      RD_PTR_M1: raddr = ptr_m1[IDX_W-1:0];
      RD_PTR_P1: raddr = ptr_p1[IDX_W-1:0];
      RD_IDX:    raddr = IDX_W'(req_r.region_index);
      default:   raddr = ptr_r[IDX_W-1:0];
    endcase
  end

  // write port: shifts, new region, resized region
  always_comb begin
    we    = 1'b0;
    waddr = ptr_r[IDX_W-1:0];
    wdata = ram_q;
    if (cmd.wr_shift) begin
      we = 1'b1;
    end else if (cmd.res_ld && cmd.res_kind == RK_INS_OK) begin
      we    = 1'b1;
      wdata = '{rstart: req_r.region_start, rend: req_r.region_end,
                rflags: req_r.region_flags};
    end else if (cmd.res_ld && cmd.res_kind == RK_RS_OK) begin
      we    = 1'b1;
      waddr = IDX_W'(req_r.region_index);
      wdata = '{rstart: req_r.region_start, rend: req_r.region_end,
                rflags: ram_q.rflags};
    end
  end

  // status to the controller
  assign prev_ovl = have_prev_r && (prev_end_r > req_r.region_start);
  always_comb begin
    stat.op            = op_t'(req_r.op);
    stat.cache_ok      = hit_vld_r && (CNT_W'(hit_idx_r) < cnt_r);
    stat.idx_bad       = idx_ext >= cnt_r;
    stat.ins_bad       = req_r.region_start >= req_r.region_end;
    stat.full          = cnt_r >= CNT_W'(MAX_REGIONS);
    stat.ptr_lt_cnt    = ptr_r < cnt_r;
    stat.ptr_gt_pos    = ptr_r > pos_r;
    stat.ptr_p1_lt_cnt = ptr_p1 < cnt_r;
    stat.contains      = (ram_q.rstart <= req_r.lookup_address) &&
                         (req_r.lookup_address < ram_q.rend);
    stat.start_le_s    = ram_q.rstart <= req_r.region_start;
    stat.ovl_end       = prev_ovl;
    stat.ovl_next      = prev_ovl || (ram_q.rstart < req_r.region_end);
    stat.rs_bad        = ((req_r.region_start & PAGE_MASK) != 64'd0) ||
                         ((req_r.region_end & PAGE_MASK) != 64'd0) ||
                         (req_r.region_start >= req_r.region_end) ||
                         !((ram_q.rstart <= req_r.region_start) &&
                           (req_r.region_end <= ram_q.rend));
    stat.out_free      = !out_vld_r || out_ready;
  end

  // pointer
  always_comb begin
    case (cmd.ptr_op)
      P_HOLD:  ptr_nxt = ptr_r;
      P_ZERO:  ptr_nxt = '0;
      P_INC:   ptr_nxt = ptr_p1;
      P_DEC:   ptr_nxt = ptr_m1;
      P_CNT:   ptr_nxt = cnt_r;
      P_IDX:   ptr_nxt = idx_ext;
      P_HIT:   ptr_nxt = CNT_W'(hit_idx_r);
      default: ptr_nxt = ptr_r;
    endcase
  end

  // result word and bookkeeping side effects
  always_comb begin
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    hit_idx_nxt   = hit_idx_r;
    hit_vld_nxt   = hit_vld_r;
    have_prev_nxt = have_prev_r;
    out_vld_nxt   = out_vld_r;
    out_nxt       = res_r;
    out_nxt.regions_in_use = 5'(cnt_r);
    if (cmd.prev_clr) begin
      have_prev_nxt = 1'b0;
    end else if (cmd.prev_ld) begin
      have_prev_nxt = 1'b1;
    end
    if (cmd.res_ld) begin
      res_nxt = '0;
      case (cmd.res_kind)
        RK_NOT_FOUND: res_nxt.status = ST_NOT_FOUND;
        RK_HIT: begin
          res_nxt.status      = ST_OK;
          res_nxt.hit         = 1'b1;
          res_nxt.found_index = 4'(ptr_r);
          res_nxt.found_start = ram_q.rstart;
          res_nxt.found_end   = ram_q.rend;
          res_nxt.found_flags = ram_q.rflags;
          hit_idx_nxt         = ptr_r[IDX_W-1:0];
          hit_vld_nxt         = 1'b1;
        end
        RK_INVALID, RK_OVERLAP, RK_FULL: begin
          res_nxt.status      = (cmd.res_kind == RK_INVALID) ? ST_INVALID :
                                (cmd.res_kind == RK_OVERLAP) ? ST_OVERLAP : ST_FULL;
          res_nxt.found_start = req_r.region_start;
          res_nxt.found_end   = req_r.region_end;
          res_nxt.found_flags = req_r.region_flags;
        end
        RK_BAD_INDEX: begin
          res_nxt.status      = ST_BAD_INDEX;
          res_nxt.found_index = req_r.region_index;
        end
        RK_RS_BAD: begin
          res_nxt.status      = ST_INVALID;
          res_nxt.found_index = req_r.region_index;
          res_nxt.found_start = ram_q.rstart;
          res_nxt.found_end   = ram_q.rend;
          res_nxt.found_flags = ram_q.rflags;
        end
        RK_RS_OK: begin
          res_nxt.status      = ST_OK;
          res_nxt.found_index = req_r.region_index;
          res_nxt.found_start = req_r.region_start;
          res_nxt.found_end   = req_r.region_end;
          res_nxt.found_flags = ram_q.rflags;
        end
        RK_INS_OK: begin
          res_nxt.status      = ST_OK;
          res_nxt.found_index = 4'(ptr_r);
          res_nxt.found_start = req_r.region_start;
          res_nxt.found_end   = req_r.region_end;
          res_nxt.found_flags = req_r.region_flags;
          cnt_nxt             = cnt_r + CNT_W'(1);
          hit_vld_nxt         = 1'b0;
        end
        RK_RM_OK: begin
          res_nxt.status      = ST_OK;
          res_nxt.found_index = req_r.region_index;
          res_nxt.found_start = cap_r.rstart;
          res_nxt.found_end   = cap_r.rend;
          res_nxt.found_flags = cap_r.rflags;
          cnt_nxt             = cnt_r - CNT_W'(1);
          hit_vld_nxt         = 1'b0;
        end
        default: res_nxt.status = ST_NOT_FOUND;
      endcase
    end
    // output register
    if (cmd.out_ld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      hit_idx_r   <= '0;
      hit_vld_r   <= 1'b0;
      have_prev_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      hit_idx_r   <= hit_idx_nxt;
      hit_vld_r   <= hit_vld_nxt;
      have_prev_r <= have_prev_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    ptr_r <= ptr_nxt;
    if (cmd.pos_ld) begin
      pos_r <= ptr_r;
    end
    if (cmd.prev_ld) begin
      prev_end_r <= ram_q.rend;
    end
    if (cmd.cap_ld) begin
      cap_r <= ram_q;
    end
    res_r <= res_nxt;
    if (cmd.out_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // checks
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_REGIONS))
    else $error("region count above table size");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    hit_vld_r |-> (CNT_W'(hit_idx_r) < cnt_r))
    else $error("remembered hit points past the table");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_ld && cmd.res_kind == RK_INS_OK) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow the table by one");

endmodule

>>> design/art_ctrl.sv
module art_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output art_pkg::dp_cmd_t  cmd,
  input  art_pkg::dp_stat_t stat
);
  import art_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_LOOKUP: begin
            if (stat.cache_ok) begin
              cmd.ptr_op = P_HIT;
              state_nxt  = S_LK_CCHK;
            end else begin
              cmd.ptr_op = P_ZERO;
              state_nxt  = S_LK_RD;
            end
          end
          OP_INSERT: begin
            if (stat.ins_bad) begin
              cmd.res_ld   = 1'b1;
              cmd.res_kind = RK_INVALID;
              state_nxt    = S_OUT;
            end else begin
              cmd.ptr_op   = P_ZERO;
              cmd.prev_clr = 1'b1;
              state_nxt    = S_IN_RD;
            end
          end
          default: begin
            if (stat.idx_bad) begin
              cmd.res_ld   = 1'b1;
              cmd.res_kind = RK_BAD_INDEX;
              state_nxt    = S_OUT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_IDX;
              state_nxt  = (stat.op == OP_RESIZE) ? S_RS_CHK : S_RM_CAP;
            end
          end
        endcase
      end
      // remembered hit: read it first
      S_LK_CCHK: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PTR;
        state_nxt  = S_LK_CRES;
      end
      // a stale remembered hit restarts the walk from entry zero
      S_LK_CRES: begin
        if (stat.contains) begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = RK_HIT;
          state_nxt    = S_OUT;
        end else begin
          cmd.ptr_op = P_ZERO;
          state_nxt  = S_LK_RD;
        end
      end
      S_LK_RD: begin
        if (stat.ptr_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_nxt  = S_LK_CHK;
        end else begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = RK_NOT_FOUND;
          state_nxt    = S_OUT;
        end
      end
      S_LK_CHK: begin
        if (stat.contains) begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = RK_HIT;
          state_nxt    = S_OUT;
        end else begin
          cmd.ptr_op = P_INC;
          state_nxt  = S_LK_RD;
        end
      end
      // insert: find the sorted position
      S_IN_RD: begin
        if (stat.ptr_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_nxt  = S_IN_CHK;
        end else if (stat.ovl_end) begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = RK_OVERLAP;
          state_nxt    = S_OUT;
        end else if (stat.full) begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = RK_FULL;
          state_nxt    = S_OUT;
        end else begin
          cmd.pos_ld = 1'b1;
          cmd.ptr_op = P_CNT;
          state_nxt  = S_IN_SH;
        end
      end
      S_IN_CHK: begin
        if (stat.start_le_s) begin
          cmd.prev_ld = 1'b1;
          cmd.ptr_op  = P_INC;
          state_nxt   = S_IN_RD;
        end else if (stat.ovl_next) begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = RK_OVERLAP;
          state_nxt    = S_OUT;
        end else if (stat.full) begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = RK_FULL;
          state_nxt    = S_OUT;
        end else begin
          cmd.pos_ld = 1'b1;
          cmd.ptr_op = P_CNT;
          state_nxt  = S_IN_SH;
        end
      end
      // insert: open a slot, moving entries up from the top
      S_IN_SH: begin
        if (stat.ptr_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M1;
          state_nxt  = S_IN_WR;
        end else begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = RK_INS_OK;
          state_nxt    = S_OUT;
        end
      end
      S_IN_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_op   = P_DEC;
        state_nxt    = S_IN_SH;
      end
      S_RS_CHK: begin
        cmd.res_ld   = 1'b1;
        cmd.res_kind = stat.rs_bad ? RK_RS_BAD : RK_RS_OK;
        state_nxt    = S_OUT;
      end
      // remove: keep the old entry, then close the gap
      S_RM_CAP: begin
        cmd.cap_ld = 1'b1;
        cmd.ptr_op = P_IDX;
        state_nxt  = S_RM_SH;
      end
      S_RM_SH: begin
        if (stat.ptr_p1_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_P1;
          state_nxt  = S_RM_WR;
        end else begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = RK_RM_OK;
          state_nxt    = S_OUT;
        end
      end
      S_RM_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_op   = P_INC;
        state_nxt    = S_RM_SH;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // checks
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (state_r == S_OUT))
    else $error("result loaded outside the output state");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && stat.out_free) |=> (state_r == S_IDLE))
    else $error("output state did not return to idle");

  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> $past(cmd.rd_en))
    else $error("shift write without a preceding read");

endmodule

>>> tb/region_table_checker.sv
`timescale 1ns / 1ps

module region_table_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  art_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  art_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 words_pending
);
  import art_pkg::*;

  // shadow copy of the region table
  logic [63:0] shadow_start [MAX_REGIONS];
  logic [63:0] shadow_end   [MAX_REGIONS];
  logic [15:0] shadow_flags [MAX_REGIONS];
  int          shadow_count;
  int          cached_index;
  bit          cached_valid;

  out_word_t expected_words [$];

  assign words_pending = expected_words.size();

  function automatic out_word_t make_word(status_t st, logic h, int idx,
                                          logic [63:0] s, logic [63:0] e,
                                          logic [15:0] f);
    out_word_t w;
    w.status         = st;
    w.hit            = h;
    w.found_index    = idx[3:0];
    w.found_start    = s;
    w.found_end      = e;
    w.found_flags    = f;
    w.regions_in_use = shadow_count[4:0];
    return w;
  endfunction

  // apply one operation to the shadow table and return its result
  function automatic out_word_t apply_region_op(in_word_t w);
    int          i;
    int          pos;
    bit          found;
    logic [63:0] s;
    logic [63:0] e;
    logic [15:0] f;
    int          idx;
    s = w.region_start;
    e = w.region_end;
    f = w.region_flags;
    idx = w.region_index;
    found = 0;
    pos = 0;
    case (op_t'(w.op))
      OP_LOOKUP: begin
        if (cached_valid && cached_index < shadow_count &&
            shadow_start[cached_index] <= w.lookup_address &&
            w.lookup_address < shadow_end[cached_index]) begin
          pos = cached_index;
          found = 1;
        end else begin
          for (i = 0; i < shadow_count && !found; i++)
            if (shadow_start[i] <= w.lookup_address &&
                w.lookup_address < shadow_end[i]) begin
              pos = i;
              found = 1;
            end
        end
        if (!found) return make_word(ST_NOT_FOUND, 0, 0, 0, 0, 0);
        cached_index = pos;
        cached_valid = 1;
        return make_word(ST_OK, 1, pos, shadow_start[pos], shadow_end[pos],
                         shadow_flags[pos]);
      end
      OP_INSERT: begin
        if (s >= e) return make_word(ST_INVALID, 0, 0, s, e, f);
        while (pos < shadow_count && shadow_start[pos] <= s) pos++;
        if ((pos > 0 && shadow_end[pos-1] > s) ||
            (pos < shadow_count && shadow_start[pos] < e))
          return make_word(ST_OVERLAP, 0, 0, s, e, f);
        if (shadow_count >= MAX_REGIONS) return make_word(ST_FULL, 0, 0, s, e, f);
        for (i = shadow_count; i > pos; i--) begin
          shadow_start[i] = shadow_start[i-1];
          shadow_end[i]   = shadow_end[i-1];
          shadow_flags[i] = shadow_flags[i-1];
        end
        shadow_start[pos] = s;
        shadow_end[pos]   = e;
        shadow_flags[pos] = f;
        shadow_count++;
        cached_valid = 0;
        return make_word(ST_OK, 0, pos, s, e, f);
      end
      OP_RESIZE: begin
        if (idx >= shadow_count) return make_word(ST_BAD_INDEX, 0, idx, 0, 0, 0);
        if ((s & PAGE_MASK) != 0 || (e & PAGE_MASK) != 0 || s >= e ||
            !(shadow_start[idx] <= s && e <= shadow_end[idx]))
          return make_word(ST_INVALID, 0, idx, shadow_start[idx], shadow_end[idx],
                           shadow_flags[idx]);
        shadow_start[idx] = s;
        shadow_end[idx]   = e;
        return make_word(ST_OK, 0, idx, s, e, shadow_flags[idx]);
      end
      default: begin
        if (idx >= shadow_count) return make_word(ST_BAD_INDEX, 0, idx, 0, 0, 0);
        s = shadow_start[idx];
        e = shadow_end[idx];
        f = shadow_flags[idx];
        for (i = idx; i + 1 < shadow_count; i++) begin
          shadow_start[i] = shadow_start[i+1];
          shadow_end[i]   = shadow_end[i+1];
          shadow_flags[i] = shadow_flags[i+1];
        end
        shadow_count--;
        cached_valid = 0;
        return make_word(ST_OK, 0, idx, s, e, f);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count   = 0;
    shadow_count = 0;
    cached_index = 0;
    cached_valid = 0;
  end

  // predict on accepted input words, compare accepted output words
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && in_valid && in_ready)
      expected_words.push_back(apply_region_op(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_data, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.hit != want.hit)
          report_mismatch("hit", out_data.hit, want.hit);
        if (out_data.found_index != want.found_index)
          report_mismatch("found_index", out_data.found_index, want.found_index);
        if (out_data.found_start != want.found_start)
          report_mismatch("found_start", out_data.found_start, want.found_start);
        if (out_data.found_end != want.found_end)
          report_mismatch("found_end", out_data.found_end, want.found_end);
        if (out_data.found_flags != want.found_flags)
          report_mismatch("found_flags", out_data.found_flags, want.found_flags);
        if (out_data.regions_in_use != want.regions_in_use)
          report_mismatch("regions_in_use", out_data.regions_in_use,
                          want.regions_in_use);
      end
    end
  end

endmodule

>>> tb/address_region_table_top_test.sv
`timescale 1ns / 1ps

module address_region_table_top_test;
  import art_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  int        fail_count;
  int        words_pending;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        i;

  // stimulus-side list of region bounds; no task in this bench reads or fills it
  logic [63:0] base_list [$];

  address_region_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  region_table_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // valid stays high after acceptance only when the next word follows at once
  task automatic send_word(op_t op, logic [63:0] addr, logic [63:0] s,
                           logic [63:0] e, logic [15:0] f, logic [3:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= '{op: op, lookup_address: addr, region_start: s, region_end: e,
                  region_flags: f, region_index: idx};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // mostly page-aligned regions in a small window so they collide and hit
  task automatic random_word();
    int          sel;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] a;
    sel = $urandom_range(99);
    s = {$urandom_range(63), 12'h000};
    e = s + {$urandom_range(8), 12'h000};
    a = s + $urandom_range(16'h2fff);
    if (sel < 5) begin
      s = rand64();
      e = rand64();
      a = rand64();
    end else if (sel < 8) begin
      s = s + $urandom_range(4095);
    end
    case ($urandom_range(9))
      0, 1, 2: send_word(OP_INSERT, rand64(), s, e, $urandom(), $urandom());
      3, 4, 5: send_word(OP_LOOKUP, a, rand64(), rand64(), $urandom(), $urandom());
      6, 7:    send_word(OP_RESIZE, rand64(), s, e, $urandom(), $urandom_range(15));
      default: send_word(OP_REMOVE, rand64(), rand64(), rand64(), $urandom(),
                         $urandom_range(15));
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n          = 0;
    in_valid       = 0;
    in_data        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table cases
    send_word(OP_LOOKUP, 64'h0, 0, 0, 0, 0);
    send_word(OP_RESIZE, 0, 64'h1000, 64'h2000, 0, 4'hf);
    send_word(OP_REMOVE, 0, 0, 0, 0, 0);
    send_word(OP_INSERT, 0, 64'h5000, 64'h5000, 16'hffff, 0);
    send_word(OP_INSERT, 0, 64'hffff_ffff_ffff_ffff, 64'h0, 16'h0, 0);
    // extremes of the address space
    send_word(OP_INSERT, 0, 64'h0, 64'h1000, 16'hffff, 0);
    send_word(OP_INSERT, 0, 64'hffff_ffff_ffff_f000, 64'hffff_ffff_ffff_ffff, 16'ha5a5, 0);
    send_word(OP_INSERT, 0, 64'h8000, 64'h10000, 16'h1234, 0);
    // overlaps, same start
    send_word(OP_INSERT, 0, 64'h8000, 64'h9000, 0, 0);
    send_word(OP_INSERT, 0, 64'h7000, 64'h8001, 0, 0);
    send_word(OP_INSERT, 0, 64'hfff, 64'h2000, 0, 0);
    // lookups: hit, cached hit, stale cache, miss at end bound
    send_word(OP_LOOKUP, 64'h8800, 0, 0, 0, 0);
    send_word(OP_LOOKUP, 64'h8000, 0, 0, 0, 0);
    send_word(OP_LOOKUP, 64'hffff_ffff_ffff_fffe, 0, 0, 0, 0);
    send_word(OP_LOOKUP, 64'h10000, 0, 0, 0, 0);
    send_word(OP_LOOKUP, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0);
    // resize: ok, unaligned, inverted, outside
    send_word(OP_RESIZE, 0, 64'h9000, 64'hf000, 0, 1);
    send_word(OP_RESIZE, 0, 64'h9001, 64'hf000, 0, 1);
    send_word(OP_RESIZE, 0, 64'hf000, 64'h9000, 0, 1);
    send_word(OP_RESIZE, 0, 64'h8000, 64'hf000, 0, 1);
    send_word(OP_LOOKUP, 64'h9000, 0, 0, 0, 0);
    send_word(OP_REMOVE, 0, 0, 0, 0, 3);
    send_word(OP_REMOVE, 0, 0, 0, 0, 0);
    send_word(OP_LOOKUP, 64'h9000, 0, 0, 0, 0);
    // fill the table to overflow
    for (i = 0; i < 17; i++)
      send_word(OP_INSERT, 0, {i[31:0] + 32'h100, 12'h0}, {i[31:0] + 32'h101, 12'h0},
                i[15:0], 0);
    drain();
    // empty it again so random phase starts small
    for (i = 0; i < 16; i++) send_word(OP_REMOVE, 0, 0, 0, 0, 0);
    drain();

    // random phases with different idling
    for (i = 0; i < 1400; i++) begin
      case (i / 280)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        3: begin send_idle_pct = 32; recv_stall_pct = 32; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (i == 700) drain();
      random_word();
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
design/art_pkg.sv
design/art_ram.sv
design/art_datapath.sv
design/art_ctrl.sv
design/address_region_table_top.sv
tb/region_table_checker.sv
tb/address_region_table_top_test.sv
